// File: rtl/sli_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted insertion list.
package sli_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic place;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic full;
    logic scan_end;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/sli_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sli_datapath.sv
`timescale 1ns / 1ps
// Datapath of the sorted list: entry memory, scan counters, compare and result register.
module sli_datapath import sli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    command,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [POS_W-1:0]        position,
  output logic [CNT_W-1:0]        count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                    cmd_r;
  logic signed [VAL_W-1:0] val_r;
  logic [CW-1:0]           entry_count;
  logic [CW-1:0]           count_next;
  logic [AW-1:0]           ptr;
  logic [CW-1:0]           left;
  logic                    rd_vld;
  logic [AW-1:0]           rd_idx;
  logic [AW-1:0]           pos_r;
  logic                    found_r;
  logic                    full_r;
  status_t                 status_r;
  status_t                 status_next;
  logic [POS_W-1:0]        pos_out;
  logic [CNT_W-1:0]        cnt_out;

  logic                    is_ins;
  logic                    issue;
  logic                    cmp;
  logic                    ge;
  logic                    stop_now;
  logic                    full_now;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [VAL_W-1:0]        wdata;
  logic [VAL_W-1:0]        rdata;
  logic [AW+POS_W-1:0]     pos_ext;
  logic [CW+CNT_W-1:0]     cnt_ext;

  assign is_ins   = (cmd_r == CMD_INSERT);
  assign full_now = (entry_count == CW'(CAPACITY));
  assign issue    = cmd.scan && (left != '0);
  assign cmp      = cmd.scan && rd_vld;
  assign ge       = ($signed(rdata) >= val_r);
  // An insert scans downwards and stops at the first entry below the new value.
  assign stop_now = cmp && is_ins && !ge;

  sli_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (issue),
    .raddr(ptr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = rd_idx + AW'(1);
    wdata = rdata;
    if (cmd.place) begin
      we    = 1'b1;
      waddr = pos_r;
      wdata = val_r;
    end else if (cmp && is_ins && ge) begin
      we    = 1'b1;
      waddr = rd_idx + AW'(1);
    end else if (cmp && !is_ins && found_r) begin
      // Entries above the removed one each move down by one place.
      we    = 1'b1;
      waddr = rd_idx - AW'(1);
    end
  end

  always_comb begin
    count_next  = entry_count;
    status_next = ST_DONE;
    if (full_r) begin
      status_next = ST_FULL;
    end else if (is_ins) begin
      count_next = entry_count + CW'(1);
    end else if (found_r) begin
      count_next = entry_count - CW'(1);
    end else begin
      status_next = ST_NOT_FOUND;
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, pos_r};
  assign cnt_ext = {{CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.emit) begin
        entry_count <= count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= command;
      val_r   <= value;
      pos_r   <= '0;
      found_r <= 1'b0;
      full_r  <= (command == CMD_INSERT) && full_now;
      if (command == CMD_INSERT) begin
        ptr  <= AW'(entry_count - CW'(1));
        left <= full_now ? '0 : entry_count;
      end else begin
        ptr  <= '0;
        left <= entry_count;
      end
    end else begin
      if (issue) begin
        ptr    <= is_ins ? ptr - AW'(1) : ptr + AW'(1);
        left   <= left - CW'(1);
        rd_idx <= ptr;
      end
      if (stop_now) begin
        pos_r <= rd_idx + AW'(1);
      end
      if (cmp && !is_ins && !found_r && (rdata == val_r)) begin
        found_r <= 1'b1;
        pos_r   <= rd_idx;
      end
    end
    if (cmd.emit) begin
      status_r <= status_next;
      pos_out  <= (status_next == ST_DONE) ? pos_ext[POS_W-1:0] : '0;
      cnt_out  <= cnt_ext[CNT_W-1:0];
    end
  end

  assign stat.is_insert = is_ins;
  assign stat.full      = full_r;
  assign stat.scan_end  = (left == '0) || stop_now;
  assign stat.out_free  = !out_valid || out_ready;

  assign status   = status_r;
  assign position = pos_out;
  assign count    = cnt_out;

endmodule

// File: rtl/sli_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences load, scan, placement and result of each command.
module sli_ctrl import sli_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_PLACE  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = (stat.is_insert && !stat.full) ? S_PLACE : S_FINISH;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/sorted_list_insert_delete_top.sv
`timescale 1ns / 1ps
// Top level of the sorted insertion list: controller and datapath.
//
//   channel | direction | handshake           | beat contents
//   in      | input     | in_valid / in_ready | command, value
//   out     | output    | out_valid/out_ready | status, position, count
//
// One command is in service at a time. The entries live in a RAM with one read
// and one write port that is walked one entry per cycle. A delete walks all the
// stored entries; an insert walks down from the top, stops early on passing its
// place and then writes the new value there; an insert into a full list walks
// none of them. in_ready rises in the cycle in which the result appears.
// Reset empties the list. A result waiting on a stalled output holds the block in
// its final state with in_ready low.
module sorted_list_insert_delete_top import sli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    command,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [POS_W-1:0]        position,
  output logic [CNT_W-1:0]        count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sli_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sli_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .command  (command),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .position (position),
    .count    (count)
  );

endmodule

// File: rtl/sli_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sorted insertion list, bound to the top level.
module sli_checker import sli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              status,
  input logic [POS_W-1:0]        position,
  input logic [CNT_W-1:0]        count
);

  // Only one command is in service, so an accepted beat closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a command is in service");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_DONE)) |-> (position == '0))
    else $error("position not zero on a command that did nothing");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> ((CAPACITY > 31) || (32'(count) == CAPACITY)))
    else $error("insert reported full with the list not full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((CAPACITY > 31) || (32'(count) <= CAPACITY)))
    else $error("count above capacity");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(position)
                                   && $stable(count)))
    else $error("stalled result beat changed");

endmodule

bind sorted_list_insert_delete_top sli_checker #(
  .CAPACITY(CAPACITY)
) u_sli_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .status   (status),
  .position (position),
  .count    (count)
);

// File: sim/sorted_list_insert_delete_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted insertion list top level.
module sorted_list_insert_delete_top_test;
  import sli_pkg::*;

  localparam int CAPACITY = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic                    cmd;
    logic signed [VAL_W-1:0] val;
  } list_cmd_t;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    command = CMD_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic [POS_W-1:0]        position;
  logic [CNT_W-1:0]        count;

  list_cmd_t               pending_cmds[$];
  list_result_t            expected_results[$];
  logic signed [VAL_W-1:0] seen_values[$];

  // Shadow copy of the list, updated as each input beat is accepted.
  logic signed [VAL_W-1:0] held[CAPACITY];
  int                      held_count = 0;

  int send_idle_pct = 28;
  int recv_idle_pct = 75;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  sorted_list_insert_delete_top #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .position (position),
    .count    (count)
  );

  always #5 clk = ~clk;

  function automatic list_result_t apply_command(input logic cmd,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t r;
    int           slot;
    r.status = ST_DONE;
    r.pos = '0;
    r.cnt = held_count[CNT_W-1:0];
    if (cmd == CMD_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
        return r;
      end
      slot = held_count;
      for (int i = 0; i < held_count; i++) begin
        if (held[i] >= val) begin
          slot = i;
          break;
        end
      end
      for (int i = held_count; i > slot; i--) held[i] = held[i-1];
      held[slot] = val;
      held_count++;
    end else begin
      slot = -1;
      for (int i = 0; i < held_count; i++) begin
        if (held[i] == val) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        r.status = ST_NOT_FOUND;
        return r;
      end
      for (int i = slot; i + 1 < held_count; i++) held[i] = held[i+1];
      held_count--;
    end
    r.pos = slot[POS_W-1:0];
    r.cnt = held_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4: v = $urandom_range(0, 16) - 8;
      5: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        if (seen_values.size() != 0) v = seen_values[$urandom_range(0, seen_values.size() - 1)];
        else v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic push_cmd(input logic cmd, input logic signed [VAL_W-1:0] val);
    list_cmd_t c;
    c.cmd = cmd;
    c.val = val;
    pending_cmds.push_back(c);
  endtask

  // Runs of mostly inserts alternate with runs of mostly deletes, so the list
  // keeps swinging between full and empty. Four values in ten reuse an earlier insert.
  task automatic queue_random(input int n);
    logic cmd;
    logic signed [VAL_W-1:0] v;
    int insert_pct;
    for (int k = 0; k < n; k++) begin
      insert_pct = ((k / 30) % 2 == 0) ? 80 : 20;
      cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
      v = pick_value();
      if (cmd == CMD_INSERT) begin
        seen_values.push_back(v);
        if (seen_values.size() > 64) void'(seen_values.pop_front());
      end
      push_cmd(cmd, v);
    end
  endtask

  // Sampled on the falling edge so that every update of the rising edge has settled.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Driver: holds each beat until accepted, then offers the next or idles.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(apply_command(command, value));
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          command  <= pending_cmds[0].cmd;
          value    <= pending_cmds[0].val;
          in_valid <= 1'b1;
          void'(pending_cmds.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random ready, with an occasional long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_ticket;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d position %0d count %0d",
                   status, position, count);
      end else begin
        if (status !== expected_results[0].status || position !== expected_results[0].pos ||
            count !== expected_results[0].cnt) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d position %0d count %0d, got %0d %0d %0d",
                     expected_results[0].status, expected_results[0].pos,
                     expected_results[0].cnt, status, position, count);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, extremes, equal values, filling up and the full case.
    push_cmd(CMD_DELETE, 32'sd5);
    push_cmd(CMD_INSERT, 32'sh7fff_ffff);
    push_cmd(CMD_INSERT, 32'sh8000_0000);
    push_cmd(CMD_INSERT, 32'sd0);
    push_cmd(CMD_INSERT, -32'sd1);
    push_cmd(CMD_INSERT, 32'sd0);
    push_cmd(CMD_DELETE, 32'sd0);
    push_cmd(CMD_DELETE, 32'sd12345);
    for (int k = 0; k < 12; k++)
      push_cmd(CMD_INSERT, (k % 2 == 0) ? (32'sh5555_5555 ^ k) : (32'shaaaa_aaaa ^ k));
    push_cmd(CMD_INSERT, 32'sd7);
    push_cmd(CMD_DELETE, 32'sh7fff_ffff);
    push_cmd(CMD_DELETE, 32'sh8000_0000);

    queue_random(140);
    wait_drained();

    send_idle_pct = 75;
    recv_idle_pct = 28;
    queue_random(140);
    wait_drained();

    // No idling; the receiver stalls for a long stretch while beats keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(120);
    hold_ticket = hold_ticket + 1;
    wait_drained();

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/sli_pkg.sv
rtl/sli_ram.sv
rtl/sli_datapath.sv
rtl/sli_ctrl.sv
rtl/sorted_list_insert_delete_top.sv
rtl/sli_checker.sv
sim/sorted_list_insert_delete_top_test.sv
